@@ src/loop_trip_count_defines.svh @@
// Assertion macros shared by the loop trip count RTL.
`ifndef LOOP_TRIP_COUNT_DEFINES_SVH
`define LOOP_TRIP_COUNT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every clock edge out of reset.
`define LTC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("loop_trip_count assertion failed");
// Next-cycle implication.
`define LTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("loop_trip_count assertion failed");
`else
`define LTC_ASSERT_IMPL(label, ante, cons)
`define LTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/ltc_pkg.sv @@
// Shared types and constants for the loop trip count block.
`default_nettype none
package ltc_pkg;
	localparam int INDEX_WIDTH_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 20;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 20'd100000;
	// register index taken from paddr[ADDR_W-1:2]
	localparam logic REG_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		OP_LT = 3'd0,
		OP_GT = 3'd1,
		OP_LE = 3'd2,
		OP_GE = 3'd3,
		OP_NE = 3'd4,
		OP_EQ = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_ONE,
		RES_LIMIT,
		RES_ORD,
		RES_NE
	} res_kind_t;

	typedef struct packed {
		res_kind_t kind;
		logic      incl;
		logic      q_neg;
	} ctx_t;
endpackage
`default_nettype wire

@@ src/ltc_front.sv @@
// Front stage: classifies the loop, forms the numerator and operand magnitudes.
`default_nettype none
`include "loop_trip_count_defines.svh"
module ltc_front import ltc_pkg::*; #(
	parameter int W = INDEX_WIDTH_DEF,
	parameter int XW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           op,
	input  wire logic signed [FIELD_W-1:0] start_value,
	input  wire logic signed [FIELD_W-1:0] end_value,
	input  wire logic signed [FIELD_W-1:0] step,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ctx_t                      ctx,
	output logic signed [XW-1:0]      num,
	output logic signed [XW-1:0]      dvs,
	output logic signed [XW-1:0]      sv,
	output logic [W-1:0]              nmag,
	output logic [W-1:0]              dmag
);
	localparam logic signed [XW-1:0] IDX_MAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] IDX_MIN = ~IDX_MAX;

	logic signed [XW-1:0] s_x, e_x, d_x, span, rnd, num_ord, nsel, nabs, dabs;
	logic in_rng, fwd, dist_ok, ord_ok;
	ctx_t ctx_c;

	logic valid_q;
	ctx_t ctx_q;
	logic signed [XW-1:0] num_q, dvs_q, sv_q;
	logic [W-1:0] nmag_q, dmag_q;

	assign s_x = {{(XW-FIELD_W){start_value[FIELD_W-1]}}, start_value};
	assign e_x = {{(XW-FIELD_W){end_value[FIELD_W-1]}}, end_value};
	assign d_x = {{(XW-FIELD_W){step[FIELD_W-1]}}, step};

	always_comb begin
		in_rng = s_x >= IDX_MIN && s_x <= IDX_MAX && e_x >= IDX_MIN && e_x <= IDX_MAX
			&& d_x >= IDX_MIN && d_x <= IDX_MAX;
		span = e_x - s_x;
		dist_ok = span >= IDX_MIN && span <= IDX_MAX;
		rnd = d_x[XW-1] ? d_x + XW'(1) : d_x - XW'(1);
		num_ord = span + rnd;
		ord_ok = num_ord >= IDX_MIN && num_ord <= IDX_MAX;
		fwd = (op == OP_LT) || (op == OP_LE);
		ctx_c.incl = (op == OP_LE) || (op == OP_GE);
		ctx_c.kind = RES_LIMIT;
		nsel = span;
		case (op)
			OP_LT, OP_GT, OP_LE, OP_GE: begin
				nsel = num_ord;
				if (!in_rng)
					ctx_c.kind = RES_LIMIT;
				else if ((fwd && s_x > e_x) || (!fwd && s_x < e_x))
					ctx_c.kind = RES_ZERO;
				else if (d_x == '0 || (fwd == d_x[XW-1]))
					ctx_c.kind = RES_LIMIT;
				else if (!dist_ok || !ord_ok)
					ctx_c.kind = RES_LIMIT;
				else if (d_x == '1 && num_ord == IDX_MIN)
					ctx_c.kind = RES_LIMIT;
				else
					ctx_c.kind = RES_ORD;
			end
			OP_NE: begin
				if (!in_rng || d_x == '0 || !dist_ok)
					ctx_c.kind = RES_LIMIT;
				else if (d_x == '1 && span == IDX_MIN)
					ctx_c.kind = RES_LIMIT;
				else
					ctx_c.kind = RES_NE;
			end
			OP_EQ: begin
				if (start_value != end_value)
					ctx_c.kind = RES_ZERO;
				else if (step != '0)
					ctx_c.kind = RES_ONE;
				else
					ctx_c.kind = RES_LIMIT;
			end
			default: ctx_c.kind = RES_LIMIT;
		endcase
		nabs = nsel[XW-1] ? -nsel : nsel;
		dabs = d_x[XW-1] ? -d_x : d_x;
		ctx_c.q_neg = nsel[XW-1] ^ d_x[XW-1];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctx_q  <= ctx_c;
			num_q  <= nsel;
			dvs_q  <= d_x;
			sv_q   <= s_x;
			nmag_q <= nabs[W-1:0];
			dmag_q <= dabs[W-1:0];
		end
	end

	assign out_valid = valid_q;
	assign ctx = ctx_q;
	assign num = num_q;
	assign dvs = dvs_q;
	assign sv = sv_q;
	assign nmag = nmag_q;
	assign dmag = dmag_q;

	// an ordered loop that reaches the divider has numerator and step of one sign
	`LTC_ASSERT_IMPL(a_ord_sign, valid_q && ctx_q.kind == RES_ORD,
		num_q == '0 || num_q[XW-1] == dvs_q[XW-1])
	`LTC_ASSERT_IMPL(a_ord_step, valid_q && ctx_q.kind == RES_ORD, dvs_q != '0)
endmodule
`default_nettype wire

@@ src/ltc_cell.sv @@
// Divider cell: one restoring step, one quotient bit, with its own pipeline register.
`default_nettype none
`include "loop_trip_count_defines.svh"
module ltc_cell import ltc_pkg::*; #(
	parameter int W = INDEX_WIDTH_DEF,
	parameter int XW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ctx_t                 in_ctx,
	input  wire logic signed [XW-1:0] in_num,
	input  wire logic signed [XW-1:0] in_dvs,
	input  wire logic signed [XW-1:0] in_sv,
	input  wire logic [W-1:0]         in_rem,
	input  wire logic [W-1:0]         in_quo,
	input  wire logic [W-1:0]         in_dmag,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ctx_t                      out_ctx,
	output logic signed [XW-1:0]      out_num,
	output logic signed [XW-1:0]      out_dvs,
	output logic signed [XW-1:0]      out_sv,
	output logic [W-1:0]              out_rem,
	output logic [W-1:0]              out_quo,
	output logic [W-1:0]              out_dmag
);
	logic [W:0] shifted, trial;
	logic [W-1:0] rem_n, quo_n;

	logic valid_q;
	ctx_t ctx_q;
	logic signed [XW-1:0] num_q, dvs_q, sv_q;
	logic [W-1:0] rem_q, quo_q, dmag_q;

	always_comb begin
		shifted = {in_rem, in_quo[W-1]};
		trial = shifted - {1'b0, in_dmag};
		if (!trial[W]) begin
			rem_n = trial[W-1:0];
			quo_n = {in_quo[W-2:0], 1'b1};
		end else begin
			rem_n = shifted[W-1:0];
			quo_n = {in_quo[W-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctx_q  <= in_ctx;
			num_q  <= in_num;
			dvs_q  <= in_dvs;
			sv_q   <= in_sv;
			rem_q  <= rem_n;
			quo_q  <= quo_n;
			dmag_q <= in_dmag;
		end
	end

	assign out_valid = valid_q;
	assign out_ctx = ctx_q;
	assign out_num = num_q;
	assign out_dvs = dvs_q;
	assign out_sv = sv_q;
	assign out_rem = rem_q;
	assign out_quo = quo_q;
	assign out_dmag = dmag_q;

	// hold a blocked partial result
	`LTC_ASSERT_NEXT(a_cell_hold, valid_q && !out_ready,
		valid_q && $stable(quo_q) && $stable(rem_q))
endmodule
`default_nettype wire

@@ src/ltc_back.sv @@
// Back stage: overflow and exactness checks, saturation, output register.
`default_nettype none
`include "loop_trip_count_defines.svh"
module ltc_back import ltc_pkg::*; #(
	parameter int W = INDEX_WIDTH_DEF,
	parameter int XW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ctx_t                 in_ctx,
	input  wire logic signed [XW-1:0] in_num,
	input  wire logic signed [XW-1:0] in_dvs,
	input  wire logic signed [XW-1:0] in_sv,
	input  wire logic [W-1:0]         in_rem,
	input  wire logic [W-1:0]         in_quo,
	input  wire logic [W-1:0]         in_dmag,
	input  wire logic [COUNT_W-1:0]   limit,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [COUNT_W-1:0]        trip_count,
	output logic                      rejected
);
	localparam logic signed [XW-1:0] IDX_MAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] IDX_MIN = ~IDX_MAX;

	logic signed [XW-1:0] q_x, r_x, d_x, rem_s, prod, last_v, cnt, lim_x, cnt_f;
	logic exact, inc, ord_bad, ne_bad;

	logic valid_q;
	logic [COUNT_W-1:0] trip_q;
	logic rej_q;

	always_comb begin
		q_x = {{(XW-W){1'b0}}, in_quo};
		r_x = {{(XW-W){1'b0}}, in_rem};
		d_x = {{(XW-W){1'b0}}, in_dmag};
		lim_x = {{(XW-COUNT_W){1'b0}}, limit};
		rem_s = in_num[XW-1] ? -r_x : r_x;
		exact = r_x == d_x - XW'(1);
		inc = in_ctx.incl && exact;
		// step times count, rebuilt from numerator and remainder
		prod = in_num - rem_s + (inc ? in_dvs : '0);
		last_v = in_sv + prod;
		ord_bad = prod < IDX_MIN || prod > IDX_MAX || last_v < IDX_MIN || last_v > IDX_MAX;
		cnt = q_x + {{(XW-1){1'b0}}, inc};
		ne_bad = in_rem != '0 || (in_ctx.q_neg && in_quo != '0);
		case (in_ctx.kind)
			RES_ZERO:  cnt_f = '0;
			RES_ONE:   cnt_f = XW'(1);
			RES_ORD:   cnt_f = ord_bad ? lim_x : cnt;
			RES_NE:    cnt_f = ne_bad ? lim_x : q_x;
			default:   cnt_f = lim_x;
		endcase
		if (cnt_f > lim_x)
			cnt_f = lim_x;
	end

	assign in_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			trip_q <= cnt_f[COUNT_W-1:0];
			rej_q  <= cnt_f >= lim_x;
		end
	end

	assign out_valid = valid_q;
	assign trip_count = trip_q;
	assign rejected = rej_q;

	`LTC_ASSERT_NEXT(a_out_hold, valid_q && out_stall,
		valid_q && $stable(trip_q) && $stable(rej_q))
endmodule
`default_nettype wire

@@ src/loop_trip_count.sv @@
// Top level of the loop trip count block: register port and cell chain.
`default_nettype none
// Computes the iteration count of "for (i = start; i OP end; i += step)" on a
// signed INDEX_WIDTH-bit index, saturated to iteration_limit, with rejected
// set when the count reaches the limit. One item is taken per cycle while
// in_stall is low; each result passes through a front stage, a chain of
// INDEX_WIDTH divider cells producing one quotient bit each, and an output
// register. A stall on the output backs up through the chain only as far as
// the empty slots allow. iteration_limit lives at byte address 0 and resets
// to 100000.
module loop_trip_count import ltc_pkg::*; #(
	parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [2:0]                op,
	input  wire logic signed [FIELD_W-1:0] start_value,
	input  wire logic signed [FIELD_W-1:0] end_value,
	input  wire logic signed [FIELD_W-1:0] step,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [COUNT_W-1:0]             trip_count,
	output logic                           rejected,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ADDR_W-1:0]         paddr,
	input  wire logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready
);
	localparam int W = INDEX_WIDTH;
	localparam int XW = ((INDEX_WIDTH > FIELD_W) ? INDEX_WIDTH : FIELD_W) + 2;

	logic [COUNT_W-1:0] limit_q;
	logic front_ready;

	logic                 v   [0:W];
	logic                 rdy [0:W];
	ctx_t                 cx  [0:W];
	logic signed [XW-1:0] nm  [0:W];
	logic signed [XW-1:0] dv  [0:W];
	logic signed [XW-1:0] sx  [0:W];
	logic [W-1:0]         rm  [0:W];
	logic [W-1:0]         qo  [0:W];
	logic [W-1:0]         dm  [0:W];

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_LIMIT) ?
		{{(DATA_W-COUNT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_LIMIT)
			limit_q <= pwdata[COUNT_W-1:0];
	end

	assign in_stall = !front_ready;
	assign rm[0] = '0;

	ltc_front #(.W(W), .XW(XW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(front_ready),
		.op(op), .start_value(start_value), .end_value(end_value), .step(step),
		.out_valid(v[0]), .out_ready(rdy[0]),
		.ctx(cx[0]), .num(nm[0]), .dvs(dv[0]), .sv(sx[0]),
		.nmag(qo[0]), .dmag(dm[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		ltc_cell #(.W(W), .XW(XW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v[i]), .in_ready(rdy[i]),
			.in_ctx(cx[i]), .in_num(nm[i]), .in_dvs(dv[i]), .in_sv(sx[i]),
			.in_rem(rm[i]), .in_quo(qo[i]), .in_dmag(dm[i]),
			.out_valid(v[i+1]), .out_ready(rdy[i+1]),
			.out_ctx(cx[i+1]), .out_num(nm[i+1]), .out_dvs(dv[i+1]), .out_sv(sx[i+1]),
			.out_rem(rm[i+1]), .out_quo(qo[i+1]), .out_dmag(dm[i+1])
		);
	end

	ltc_back #(.W(W), .XW(XW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v[W]), .in_ready(rdy[W]),
		.in_ctx(cx[W]), .in_num(nm[W]), .in_dvs(dv[W]), .in_sv(sx[W]),
		.in_rem(rm[W]), .in_quo(qo[W]), .in_dmag(dm[W]),
		.limit(limit_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.trip_count(trip_count), .rejected(rejected)
	);
endmodule
`default_nettype wire

@@ bench/loop_trip_count_tb.sv @@
// Self-checking testbench for the loop trip count block.
`timescale 1ns / 100ps
module loop_trip_count_tb;
	import ltc_pkg::*;

	localparam longint IDX_MAX = 64'sd2147483647;
	localparam longint IDX_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [2:0] op;
		logic signed [31:0] s, e, d;
	} loop_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic rej;
	} trip_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [2:0] op = '0;
	logic signed [31:0] start_value = '0, end_value = '0, step = '0;
	logic out_valid, out_stall = 0;
	logic [COUNT_W-1:0] trip_count;
	logic rejected;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0, prdata;
	logic pready;

	loop_t pending_loops[$];
	trip_t expected_trips[$];
	logic [COUNT_W-1:0] cur_limit = LIMIT_RESET;
	bit calm = 0;
	int in_gap = 0, out_gap = 0;
	int errors = 0, checked = 0, rejects = 0, cycles = 0;

	loop_trip_count dut (.*);

	always #6 clk = ~clk;

	// Iteration count of one loop, saturated to the limit.
	function automatic trip_t trip_of(loop_t it, logic [COUNT_W-1:0] lim);
		longint s, e, d, cnt, w, q, last, lm;
		bit bad, fwd, incl;
		trip_t r;
		s = it.s; e = it.e; d = it.d; lm = lim; bad = 0;
		fwd = (it.op == OP_LT) || (it.op == OP_LE);
		incl = (it.op == OP_LE) || (it.op == OP_GE);
		if (it.op > OP_EQ) cnt = lm;
		else if (it.op == OP_EQ) cnt = (s == e) ? ((d != 0) ? 1 : lm) : 0;
		else if (it.op == OP_NE) begin
			if (d == 0) cnt = lm;
			else begin
				w = e - s;
				bad = w > IDX_MAX || w < IDX_MIN || (d == -1 && w == IDX_MIN);
				q = w / d;
				last = s + d * q;
				if (bad || d * q > IDX_MAX || d * q < IDX_MIN || last != e || q < 0 || q > lm)
					cnt = lm;
				else cnt = q;
			end
		end else if ((fwd && s > e) || (!fwd && s < e)) cnt = 0;
		else if (d == 0 || (d > 0) != fwd) cnt = lm;
		else begin
			w = e - s;
			q = w + ((d > 0) ? d - 1 : d + 1);
			bad = w > IDX_MAX || w < IDX_MIN || q > IDX_MAX || q < IDX_MIN;
			bad |= d == -1 && q == IDX_MIN;
			q = q / d;
			if (incl && w % d == 0) q++;
			bad |= q > IDX_MAX || d * q > IDX_MAX || d * q < IDX_MIN;
			last = s + d * q;
			bad |= last > IDX_MAX || last < IDX_MIN;
			cnt = (bad || q < 0 || q > lm) ? lm : q;
		end
		if (cnt > lm) cnt = lm;
		if (cnt < 0) cnt = 0;
		r.count = cnt[COUNT_W-1:0];
		r.rej = cnt >= lm;
		return r;
	endfunction

	// Input side: hold the payload while stalled, insert idle bursts.
	always @(posedge clk) begin
		loop_t it;
		if (in_valid && !in_stall) begin
			it.op = op; it.s = start_value; it.e = end_value; it.d = step;
			expected_trips.push_back(trip_of(it, cur_limit));
		end
		if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (pending_loops.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(1, 15);
				in_valid <= 0;
			end else if (pending_loops.size() != 0) begin
				it = pending_loops.pop_front();
				op <= it.op; start_value <= it.s; end_value <= it.e; step <= it.d;
				in_valid <= 1;
			end else in_valid <= 0;
		end
	end

	// Output side: random stall bursts, compare each transfer.
	always @(posedge clk) begin
		trip_t x;
		if (out_valid && !out_stall) begin
			if (expected_trips.size() == 0) begin
				$error("unexpected result trip_count=%0d rejected=%0b", trip_count, rejected);
				errors++;
			end else begin
				x = expected_trips.pop_front();
				checked++;
				rejects += x.rej;
				if (trip_count !== x.count) begin
					$error("trip_count expected %0d actual %0d", x.count, trip_count);
					errors++;
				end
				if (rejected !== x.rej) begin
					$error("rejected expected %0b actual %0b", x.rej, rejected);
					errors++;
				end
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			out_gap = $urandom_range(1, 15) - 1;
			out_stall <= 1;
		end else out_stall <= 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_limit(logic [COUNT_W-1:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= ADDR_W'(REG_LIMIT) << 2;
		pwdata <= DATA_W'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		cur_limit = v;
	endtask

	task automatic add_loop(logic [2:0] o, longint s, longint e, longint d);
		loop_t it;
		it.op = o; it.s = s[31:0]; it.e = e[31:0]; it.d = d[31:0];
		pending_loops.push_back(it);
	endtask

	// Mostly loops that end after a modest count, plus raw noise and edges.
	task automatic add_random_loop();
		longint s, d, e, n;
		int kind;
		logic [2:0] o;
		kind = $urandom_range(0, 9);
		o = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		s = longint'($signed($urandom()));
		if (kind <= 5) begin
			d = ($urandom_range(0, 3) == 0) ? $urandom() >> $urandom_range(0, 31)
				: $urandom_range(1, 1000);
			if (d == 0) d = 1;
			if (o == OP_GT || o == OP_GE || (o == OP_NE && $urandom_range(0, 1))) d = -d;
			if (kind == 5) d = -d;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1100000) : $urandom_range(0, 3000);
			e = s + d * n + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) - 2 : 0);
			add_loop(o, s, e, d);
		end else if (kind <= 7) add_loop(o, s, $signed($urandom()), $signed($urandom()));
		else if (kind == 8) add_loop(o, ($urandom_range(0, 1)) ? IDX_MIN : IDX_MAX,
			($urandom_range(0, 1)) ? IDX_MIN : IDX_MAX, $urandom_range(0, 4) - 2);
		else add_loop(OP_EQ, s, s, $urandom_range(0, 3));
	endtask

	task automatic drain();
		while (pending_loops.size() != 0 || in_valid || expected_trips.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [COUNT_W-1:0] limits[7];
		limits = '{LIMIT_RESET, 20'd1, 20'hFFFFF, 20'd0, 20'd37, 20'd2000, 20'd100000};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		add_loop(OP_LT, 0, 10, 1);
		add_loop(OP_LE, 0, 10, 2);
		add_loop(OP_GT, 10, 0, -3);
		add_loop(OP_GE, 10, 0, -5);
		add_loop(OP_NE, 0, 12, 3);
		add_loop(OP_NE, 0, 13, 3);
		add_loop(OP_NE, 0, 12, 0);
		add_loop(OP_EQ, 5, 5, 1);
		add_loop(OP_EQ, 5, 5, 0);
		add_loop(OP_EQ, 5, 6, 1);
		add_loop(OP_LT, 5, 0, 1);
		add_loop(OP_GE, 0, 5, -1);
		add_loop(OP_LT, 0, 10, 0);
		add_loop(OP_LT, 0, 10, -1);
		add_loop(OP_LT, IDX_MIN, IDX_MAX, 1);
		add_loop(OP_GT, IDX_MAX, IDX_MIN, -1);
		add_loop(OP_LE, IDX_MIN, IDX_MAX, IDX_MAX);
		add_loop(OP_GE, IDX_MAX, IDX_MIN, IDX_MIN);
		add_loop(OP_NE, IDX_MIN, IDX_MAX, -1);
		add_loop(OP_LE, 0, IDX_MAX, 1);
		add_loop(OP_LT, 0, 1000000000, 1);
		add_loop(3'd6, 0, 10, 1);
		add_loop(3'd7, 0, 10, 1);
		drain();
		foreach (limits[p]) begin
			if (p != 0) write_limit(limits[p]);
			calm = (p == 6);
			repeat (218) add_random_loop();
			drain();
		end
		$display("Checked %0d results over 7 limit settings (incl. 0, 1 and max),", checked);
		$display("%0d of them rejected.", rejects);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/ltc_pkg.sv
src/ltc_front.sv
src/ltc_cell.sv
src/ltc_back.sv
src/loop_trip_count.sv
bench/loop_trip_count_tb.sv
